FILE: sv/shpd_pkg.sv
// shared types and constants of the swing high/low pivot detector
`timescale 1ns / 1ps
`default_nettype none

package shpd_pkg;

  // window depth by default
  localparam int unsigned MAX_WINDOW_DEF = 16;

  // payload widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 32;

  // configuration widths and reset values
  localparam int unsigned WLEN_W   = 5;
  localparam int unsigned START_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IX_W = 1;

  localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST  = 5'd3;
  localparam logic [START_W-1:0] START_INDEX_RST = 16'd0;

  // register indexes
  localparam logic [CFG_IX_W-1:0] REG_WINDOW_LEN  = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_START_INDEX = 1'd1;

  // fewest window entries for which detection runs
  localparam int unsigned MIN_DETECT_FILL = 3;

  // result of the shared comparator
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: sv/shpd_cmp.sv
// shared signed magnitude comparator
`timescale 1ns / 1ps
`default_nettype none

module shpd_cmp (
  input  logic signed [shpd_pkg::VAL_W-1:0] a_i,
  input  logic signed [shpd_pkg::VAL_W-1:0] b_i,
  output shpd_pkg::cmp_res_t                res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

`default_nettype wire

FILE: sv/shpd_window.sv
// circular sample window: memory of values and indices with head and fill
`timescale 1ns / 1ps
`default_nettype none

module shpd_window #(
  parameter  int unsigned MaxWindow = shpd_pkg::MAX_WINDOW_DEF,
  localparam int unsigned AW        = $clog2(MaxWindow),
  localparam int unsigned CW        = $clog2(MaxWindow + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               upd_i,
  input  logic        [CW-1:0]               cap_i,
  input  logic signed [shpd_pkg::VAL_W-1:0]  wr_val_i,
  input  logic        [shpd_pkg::IDX_W-1:0]  wr_idx_i,
  input  logic        [AW-1:0]               rd_off_i,
  output logic        [CW-1:0]               fill_o,
  output logic signed [shpd_pkg::VAL_W-1:0]  rd_val_o,
  output logic        [shpd_pkg::IDX_W-1:0]  rd_idx_o
);

  localparam logic [CW:0] DEPTH = (CW + 1)'(MaxWindow);

  logic signed [shpd_pkg::VAL_W-1:0] val_mem [MaxWindow];
  logic        [shpd_pkg::IDX_W-1:0] idx_mem [MaxWindow];

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] f1, f2, drops;
  logic [CW:0]   hsum, wsum, rsum;
  logic [AW-1:0] wpos, raddr;
  logic          wr_en;

  always_comb begin
    // trim to the cap, then make room for the new entry
    f1 = (fill_q > cap_i) ? cap_i : fill_q;
    f2 = ((cap_i != '0) && (f1 >= cap_i)) ? f1 - 1'b1 : f1;
    drops = fill_q - f2;
    hsum = (CW + 1)'(head_q) + (CW + 1)'(drops);
    if (hsum >= DEPTH) hsum = hsum - DEPTH;
    wsum = hsum + (CW + 1)'(f2);
    if (wsum >= DEPTH) wsum = wsum - DEPTH;
    rsum = (CW + 1)'(head_q) + (CW + 1)'(rd_off_i);
    if (rsum >= DEPTH) rsum = rsum - DEPTH;
    wpos  = wsum[AW-1:0];
    raddr = rsum[AW-1:0];
    wr_en = upd_i && (cap_i != '0);
    head_d = head_q;
    fill_d = fill_q;
    if (upd_i) begin
      head_d = hsum[AW-1:0];
      fill_d = wr_en ? f2 + 1'b1 : f2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_mem[wpos] <= wr_val_i;
      idx_mem[wpos] <= wr_idx_i;
    end
    rd_val_o <= val_mem[raddr];
    rd_idx_o <= idx_mem[raddr];
  end

  assign fill_o = fill_q;

endmodule

`default_nettype wire

FILE: sv/swing_high_low_pivot_detector_top.sv
// top level of the swing high/low pivot detector: sequencer and pivot state
`timescale 1ns / 1ps
`default_nettype none

// Zigzag swing pivot detector. One signed sample is taken per input beat and
// pushed into a circular window of the last min(window_len, MaxWindow)
// samples. A running low and high are tracked; from start_index on, a low
// that is older than window_len samples is reported once as a pivot beat,
// after which the running high is reloaded with the window maximum (oldest
// entry wins ties), and the same for highs against the window minimum.
// Reports alternate low and high. An accepted sample passes the update,
// low-check, high-check and done states (the high check is skipped while
// the window holds fewer than three samples); a report adds a rescan that
// streams all fill entries (fill being the window occupancy, at most
// MaxWindow) one entry per cycle through the single shared comparator
// behind a registered read. The finished pivot sits in an output register,
// so the next sample is taken while it waits; a second pivot then holds the
// block until the first beat is taken. No clearing pass after reset.
// Configuration is to be written only while idle; the block does not enforce it.
module swing_high_low_pivot_detector_top #(
  parameter int unsigned MaxWindow = shpd_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic        [shpd_pkg::CFG_IX_W-1:0] cfg_index_i,
  input  logic        [shpd_pkg::CFG_W-1:0]    cfg_data_i,
  // sample channel
  input  logic                                sample_valid_i,
  output logic                                sample_ready_o,
  input  logic signed [shpd_pkg::VAL_W-1:0]    sample_value_i,
  // pivot channel
  output logic                                pivot_valid_o,
  input  logic                                pivot_ready_i,
  output logic signed [shpd_pkg::VAL_W-1:0]    pivot_value_o,
  output logic        [shpd_pkg::IDX_W-1:0]    pivot_index_o,
  output logic                                pivot_is_high_o
);

  localparam int unsigned AW = $clog2(MaxWindow);
  localparam int unsigned CW = $clog2(MaxWindow + 1);
  // common width for the window_len versus depth compare
  localparam int unsigned LW = (CW > shpd_pkg::WLEN_W) ? CW : shpd_pkg::WLEN_W;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_LOW  = 6'b000100,
    S_SCAN = 6'b001000,
    S_HIGH = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [shpd_pkg::WLEN_W-1:0]  wlen_q;
  logic [shpd_pkg::START_W-1:0] start_q;

  // per-sample and tracking state
  logic signed [shpd_pkg::VAL_W-1:0] samp_q;
  logic        [shpd_pkg::IDX_W-1:0] idx_q;
  logic signed [shpd_pkg::VAL_W-1:0] low_val_q, high_val_q;
  logic        [shpd_pkg::IDX_W-1:0] low_at_q, high_at_q;
  logic                              low_rep_q, high_rep_q;
  logic                              emit_q;     // this sample reports a pivot
  logic                              scan_hi_q;  // rescan looks for the maximum
  logic        [CW-1:0]              cnt_q;

  // pending result and output register
  logic signed [shpd_pkg::VAL_W-1:0] res_val_q;
  logic        [shpd_pkg::IDX_W-1:0] res_at_q;
  logic                              res_hi_q;
  logic                              out_valid_q;

  // window and comparator hookup
  logic        [CW-1:0]              cap;
  logic        [CW-1:0]              win_fill;
  logic signed [shpd_pkg::VAL_W-1:0] rd_val;
  logic        [shpd_pkg::IDX_W-1:0] rd_idx;
  logic signed [shpd_pkg::VAL_W-1:0] cmp_a, cmp_b;
  shpd_pkg::cmp_res_t                cmp_res;

  logic                              win_upd;
  logic                              enough;
  logic                              past_start;
  logic                              low_old, high_old;
  logic                              take;
  logic                              out_free;

  // window holds min(window_len, depth) entries
  always_comb begin
    if (LW'(wlen_q) < LW'(MaxWindow)) cap = CW'(wlen_q);
    else cap = CW'(MaxWindow);
  end

  assign win_upd    = (state_q == S_UPD);
  assign enough     = (win_fill >= CW'(shpd_pkg::MIN_DETECT_FILL));
  assign past_start = (idx_q >= shpd_pkg::IDX_W'(start_q));
  // ages wrap modulo the index width
  assign low_old    = ((idx_q - low_at_q) > shpd_pkg::IDX_W'(wlen_q));
  assign high_old   = ((idx_q - high_at_q) > shpd_pkg::IDX_W'(wlen_q));

  shpd_window #(
    .MaxWindow(MaxWindow)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (win_upd),
    .cap_i   (cap),
    .wr_val_i(samp_q),
    .wr_idx_i(idx_q),
    .rd_off_i(cnt_q[AW-1:0]),
    .fill_o  (win_fill),
    .rd_val_o(rd_val),
    .rd_idx_o(rd_idx)
  );

  // one comparator serves the low check, the high check and the rescan
  always_comb begin
    cmp_a = samp_q;
    cmp_b = low_val_q;
    if (state_q == S_HIGH) begin
      cmp_b = high_val_q;
    end else if (state_q == S_SCAN) begin
      cmp_a = rd_val;
      cmp_b = scan_hi_q ? high_val_q : low_val_q;
    end
  end

  shpd_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .res_o(cmp_res)
  );

  // first entry always taken, later ones only when strictly better
  assign take     = (cnt_q == CW'(1)) || (scan_hi_q ? cmp_res.gt : cmp_res.lt);
  assign out_free = !out_valid_q || pivot_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (sample_valid_i) state_d = S_UPD;
      S_UPD:  state_d = S_LOW;
      S_LOW: begin
        if (!enough) state_d = S_DONE;
        else if (cmp_res.lt) state_d = S_HIGH;
        else if (past_start && low_old && !low_rep_q) state_d = S_SCAN;
        else state_d = S_HIGH;
      end
      S_SCAN: begin
        if ((cnt_q != '0) && (cnt_q == win_fill)) state_d = scan_hi_q ? S_HIGH : S_DONE;
      end
      S_HIGH: begin
        if (cmp_res.gt) state_d = S_DONE;
        else if (past_start && high_old && !high_rep_q && !emit_q) state_d = S_SCAN;
        else state_d = S_DONE;
      end
      S_DONE: if (!emit_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= shpd_pkg::WINDOW_LEN_RST;
      start_q     <= shpd_pkg::START_INDEX_RST;
      idx_q       <= '0;
      low_rep_q   <= 1'b0;
      high_rep_q  <= 1'b0;
      emit_q      <= 1'b0;
      scan_hi_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          shpd_pkg::REG_WINDOW_LEN:  wlen_q  <= cfg_data_i[shpd_pkg::WLEN_W-1:0];
          shpd_pkg::REG_START_INDEX: start_q <= cfg_data_i[shpd_pkg::START_W-1:0];
          default: ;
        endcase
      end
      // load a finished pivot, else retire the beat taken by the receiver
      if (state_q == S_DONE && emit_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && pivot_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_UPD: emit_q <= 1'b0;
        S_LOW: begin
          if (enough && !cmp_res.lt && past_start && low_old && !low_rep_q) begin
            low_rep_q  <= 1'b1;
            high_rep_q <= 1'b0;
            emit_q     <= 1'b1;
            scan_hi_q  <= 1'b1;
            cnt_q      <= '0;
          end
        end
        S_HIGH: begin
          if (!cmp_res.gt && past_start && high_old && !high_rep_q && !emit_q) begin
            high_rep_q <= 1'b1;
            low_rep_q  <= 1'b0;
            emit_q     <= 1'b1;
            scan_hi_q  <= 1'b0;
            cnt_q      <= '0;
          end
        end
        S_SCAN: begin
          if (cnt_q != win_fill || cnt_q == '0) cnt_q <= cnt_q + 1'b1;
        end
        S_DONE: begin
          if (!emit_q || out_free) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (sample_valid_i) samp_q <= sample_value_i;
      S_UPD: begin
        // first sample and index wrap seed both running extremes
        if (idx_q == '0) begin
          low_val_q  <= samp_q;
          low_at_q   <= '0;
          high_val_q <= samp_q;
          high_at_q  <= '0;
        end
      end
      S_LOW: begin
        if (enough) begin
          if (cmp_res.lt) begin
            low_val_q <= samp_q;
            low_at_q  <= idx_q;
          end else if (past_start && low_old && !low_rep_q) begin
            res_val_q <= low_val_q;
            res_at_q  <= low_at_q;
            res_hi_q  <= 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q != '0 && take) begin
          if (scan_hi_q) begin
            high_val_q <= rd_val;
            high_at_q  <= rd_idx;
          end else begin
            low_val_q <= rd_val;
            low_at_q  <= rd_idx;
          end
        end
      end
      S_HIGH: begin
        if (cmp_res.gt) begin
          high_val_q <= samp_q;
          high_at_q  <= idx_q;
        end else if (past_start && high_old && !high_rep_q && !emit_q) begin
          res_val_q <= high_val_q;
          res_at_q  <= high_at_q;
          res_hi_q  <= 1'b1;
        end
      end
      S_DONE: begin
        if (emit_q && out_free) begin
          pivot_value_o   <= res_val_q;
          pivot_index_o   <= res_at_q;
          pivot_is_high_o <= res_hi_q;
        end
      end
      default: ;
    endcase
  end

  assign sample_ready_o = (state_q == S_IDLE);
  assign pivot_valid_o  = out_valid_q;

  // a rescan only runs over a window that allows detection
  a_scan_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (win_fill >= CW'(shpd_pkg::MIN_DETECT_FILL)))
    else $error("rescan over a short window");

  // rescan counter stays within the window
  a_scan_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= win_fill))
    else $error("rescan counter beyond fill");

  // reports alternate, so both sides are never marked reported at once
  a_rep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(low_rep_q && high_rep_q))
    else $error("both pivot sides marked reported");

  // a new pivot is only loaded into a free output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pivot_ready_i && state_q == S_DONE && emit_q) |=> out_valid_q &&
    (state_q == S_DONE))
    else $error("pivot overwritten while pending");

endmodule

`default_nettype wire
